// ===== design/ppt_pkg.sv =====
// Shared constants and types for the projective point transform.
`default_nettype none
package ppt_pkg;

  localparam int unsigned DISPLAY_HEIGHT = 800;
  localparam int unsigned COEF_W         = 48;
  localparam int unsigned PT_W           = 16;
  localparam int unsigned PROD_W         = 60;  // coeff * point floored to Q.32
  localparam int unsigned SUM_W          = 62;  // u, v, w in Q.32
  localparam int unsigned DIV_W          = 64;  // numerator and divisor magnitudes
  localparam int unsigned QBITS          = 17;  // quotient magnitude bits kept
  localparam int unsigned TRIAL_W        = DIV_W + QBITS;
  localparam int unsigned LATENCY        = 6 + QBITS;

  typedef enum logic [2:0] {
    CFG_XX = 3'd0,
    CFG_XY = 3'd1,
    CFG_XT = 3'd2,
    CFG_YX = 3'd3,
    CFG_YY = 3'd4,
    CFG_YT = 3'd5,
    CFG_WX = 3'd6,
    CFG_WY = 3'd7
  } cfg_idx_t;

  localparam logic signed [COEF_W-1:0] XX_RST = 48'sd2147483648;
  localparam logic signed [COEF_W-1:0] XY_RST = -48'sd1449551462;
  localparam logic signed [COEF_W-1:0] XT_RST = 48'sd515396075520;
  localparam logic signed [COEF_W-1:0] YX_RST = 48'sd0;
  localparam logic signed [COEF_W-1:0] YY_RST = -48'sd1395864371;
  localparam logic signed [COEF_W-1:0] YT_RST = 48'sd1116691496960;
  localparam logic signed [COEF_W-1:0] WX_RST = 48'sd0;
  localparam logic signed [COEF_W-1:0] WY_RST = -48'sd6039798;

  // Saturate a wider signed value to 16 bits.
  function automatic logic signed [PT_W-1:0] sat16(input logic signed [18:0] v);
    logic signed [PT_W-1:0] r;
    if (v > 19'sd32767) r = 16'sh7fff;
    else if (v < -19'sd32768) r = 16'sh8000;
    else r = v[PT_W-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/projective_point_transform.sv =====
// Top level of the projective point transform pipeline.
`default_nettype none
// One point enters per clock cycle whenever start is high; busy is always low,
// so there is no back-pressure. Each point comes out through the stages below,
// with out_valid high for one cycle. The depth is set by the restoring
// divider, which resolves one quotient bit per stage for the 17 bits kept
// before saturation, plus six stages for the input flip, the 48x16 products,
// the row sums, the operand setup, the range check and the output sign and
// saturation. Coefficients must only be written while no point is in
// flight.
module projective_point_transform import ppt_pkg::*; (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     start,
  output logic                    busy,
  input  wire  signed [PT_W-1:0]  in_src_x,
  input  wire  signed [PT_W-1:0]  in_src_y,
  output logic                    out_valid,
  output logic signed [PT_W-1:0]  out_dst_x,
  output logic signed [PT_W-1:0]  out_dst_y,
  output logic signed [PT_W-1:0]  out_flipped_src_y,
  output logic                    out_no_divide,
  input  wire                     cfg_we,
  input  wire  [2:0]              cfg_index,
  input  wire  [COEF_W-1:0]       cfg_data
);

  logic signed [COEF_W-1:0] cxx_r, cxy_r, cxt_r, cyx_r, cyy_r, cyt_r, cwx_r, cwy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cxx_r <= XX_RST; cxy_r <= XY_RST; cxt_r <= XT_RST;
      cyx_r <= YX_RST; cyy_r <= YY_RST; cyt_r <= YT_RST;
      cwx_r <= WX_RST; cwy_r <= WY_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_XX: cxx_r <= cfg_data;
        CFG_XY: cxy_r <= cfg_data;
        CFG_XT: cxt_r <= cfg_data;
        CFG_YX: cyx_r <= cfg_data;
        CFG_YY: cyy_r <= cfg_data;
        CFG_YT: cyt_r <= cfg_data;
        CFG_WX: cwx_r <= cfg_data;
        CFG_WY: cwy_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Stage 1: input flip.
  logic signed [18:0]     ys_wide;
  logic                   v1_r;
  logic signed [PT_W-1:0] x1_r, ys1_r;

  assign ys_wide = $signed(19'(DISPLAY_HEIGHT * 16)) - 19'(in_src_y);

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= start & ~busy;
    x1_r  <= in_src_x;
    ys1_r <= sat16(ys_wide);
  end

  // Stage 2: six products, floored to Q.32 by dropping four bits.
  logic signed [63:0] pxx, pxy, pyx, pyy, pwx, pwy;
  logic signed [PROD_W-1:0] pxx_r, pxy_r, pyx_r, pyy_r, pwx_r, pwy_r;
  logic signed [PT_W-1:0] ys2_r;
  logic v2_r;

  always_comb begin
    pxx = 64'(cxx_r) * 64'(x1_r);
    pxy = 64'(cxy_r) * 64'(ys1_r);
    pyx = 64'(cyx_r) * 64'(x1_r);
    pyy = 64'(cyy_r) * 64'(ys1_r);
    pwx = 64'(cwx_r) * 64'(x1_r);
    pwy = 64'(cwy_r) * 64'(ys1_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    pxx_r <= pxx[63:4]; pxy_r <= pxy[63:4];
    pyx_r <= pyx[63:4]; pyy_r <= pyy[63:4];
    pwx_r <= pwx[63:4]; pwy_r <= pwy[63:4];
    ys2_r <= ys1_r;
  end

  // Stage 3: row sums.
  logic signed [SUM_W-1:0] u3_r, v3_r, w3_r;
  logic signed [PT_W-1:0]  ys3_r;
  logic v3v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3v_r <= 1'b0;
    else        v3v_r <= v2_r;
    u3_r  <= SUM_W'(pxx_r) + SUM_W'(pxy_r) + SUM_W'(cxt_r);
    v3_r  <= SUM_W'(pyx_r) + SUM_W'(pyy_r) + SUM_W'(cyt_r);
    w3_r  <= SUM_W'(pwx_r) + SUM_W'(pwy_r) + (SUM_W'(1) <<< 32);
    ys3_r <= ys2_r;
  end

  // Stage 4: divider operands. A zero w turns into a divide by 2^32 of u + 2^31,
  // which rounds by the same half-divisor offset as the ratio case.
  logic signed [DIV_W-1:0] u64, v64, w64, nu, nv, dd;
  logic                    wz;
  logic [DIV_W-1:0]        mu4_r, mv4_r, md4_r;
  logic                    nxg4_r, nyg4_r, nd4_r, v4_r;
  logic signed [PT_W-1:0]  ys4_r;

  always_comb begin
    u64 = DIV_W'(u3_r);
    v64 = DIV_W'(v3_r);
    w64 = DIV_W'(w3_r);
    wz  = (w3_r == '0);
    if (wz) begin
      nu = u64 + 64'sd2147483648;
      nv = v64 + 64'sd2147483648;
      dd = 64'sd4294967296;
    end else begin
      nu = (u64 <<< 1) + w64;
      nv = (v64 <<< 1) + w64;
      dd = w64 <<< 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else        v4_r <= v3v_r;
    mu4_r  <= nu[DIV_W-1] ? DIV_W'(-nu) : DIV_W'(nu);
    mv4_r  <= nv[DIV_W-1] ? DIV_W'(-nv) : DIV_W'(nv);
    md4_r  <= dd[DIV_W-1] ? DIV_W'(-dd) : DIV_W'(dd);
    nxg4_r <= nu[DIV_W-1] ^ dd[DIV_W-1];
    nyg4_r <= nv[DIV_W-1] ^ dd[DIV_W-1];
    nd4_r  <= wz;
    ys4_r  <= ys3_r;
  end

  // Stage 5 and the divider rows: index 0 holds the range check result.
  logic [DIV_W-1:0]       rx_r [0:QBITS];
  logic [DIV_W-1:0]       ry_r [0:QBITS];
  logic [DIV_W-1:0]       dv_r [0:QBITS];
  logic [QBITS-1:0]       qx_r [0:QBITS];
  logic [QBITS-1:0]       qy_r [0:QBITS];
  logic                   ox_r [0:QBITS];
  logic                   oy_r [0:QBITS];
  logic                   sx_r [0:QBITS];
  logic                   sy_r [0:QBITS];
  logic                   nd_r [0:QBITS];
  logic                   vd_r [0:QBITS];
  logic signed [PT_W-1:0] ysd_r [0:QBITS];

  logic [DIV_W-1:0] rx_nxt [0:QBITS-1];
  logic [DIV_W-1:0] ry_nxt [0:QBITS-1];
  logic             bx_nxt [0:QBITS-1];
  logic             by_nxt [0:QBITS-1];

  // Each row tries the divisor shifted to its quotient bit and keeps the remainder.
  always_comb begin
    logic [TRIAL_W-1:0] trial;
    for (int i = 0; i < QBITS; i++) begin
      trial = TRIAL_W'(dv_r[i]) << (QBITS - 1 - i);
      bx_nxt[i] = (TRIAL_W'(rx_r[i]) >= trial);
      by_nxt[i] = (TRIAL_W'(ry_r[i]) >= trial);
      rx_nxt[i] = bx_nxt[i] ? DIV_W'(TRIAL_W'(rx_r[i]) - trial) : rx_r[i];
      ry_nxt[i] = by_nxt[i] ? DIV_W'(TRIAL_W'(ry_r[i]) - trial) : ry_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= QBITS; i++) vd_r[i] <= 1'b0;
    end else begin
      vd_r[0] <= v4_r;
      for (int i = 0; i < QBITS; i++) vd_r[i+1] <= vd_r[i];
    end
    rx_r[0]  <= mu4_r;
    ry_r[0]  <= mv4_r;
    dv_r[0]  <= md4_r;
    qx_r[0]  <= '0;
    qy_r[0]  <= '0;
    ox_r[0]  <= TRIAL_W'(mu4_r) >= (TRIAL_W'(md4_r) << QBITS);
    oy_r[0]  <= TRIAL_W'(mv4_r) >= (TRIAL_W'(md4_r) << QBITS);
    sx_r[0]  <= nxg4_r;
    sy_r[0]  <= nyg4_r;
    nd_r[0]  <= nd4_r;
    ysd_r[0] <= ys4_r;
    for (int i = 0; i < QBITS; i++) begin
      rx_r[i+1]  <= rx_nxt[i];
      ry_r[i+1]  <= ry_nxt[i];
      dv_r[i+1]  <= dv_r[i];
      qx_r[i+1]  <= {qx_r[i][QBITS-2:0], bx_nxt[i]};
      qy_r[i+1]  <= {qy_r[i][QBITS-2:0], by_nxt[i]};
      ox_r[i+1]  <= ox_r[i];
      oy_r[i+1]  <= oy_r[i];
      sx_r[i+1]  <= sx_r[i];
      sy_r[i+1]  <= sy_r[i];
      nd_r[i+1]  <= nd_r[i];
      ysd_r[i+1] <= ysd_r[i];
    end
  end

  // Output stage: sign, saturation and the y flip back.
  logic [QBITS-1:0]    magx, magy;
  logic signed [QBITS:0] qsx, qsy;
  logic signed [18:0]  dy_wide;

  always_comb begin
    magx    = ox_r[QBITS] ? '1 : qx_r[QBITS];
    magy    = oy_r[QBITS] ? '1 : qy_r[QBITS];
    qsx     = sx_r[QBITS] ? -$signed({1'b0, magx}) : $signed({1'b0, magx});
    qsy     = sy_r[QBITS] ? -$signed({1'b0, magy}) : $signed({1'b0, magy});
    dy_wide = $signed(19'(DISPLAY_HEIGHT)) - 19'(qsy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= vd_r[QBITS];
    out_dst_x         <= sat16(19'(qsx));
    out_dst_y         <= sat16(dy_wide);
    out_flipped_src_y <= ysd_r[QBITS];
    out_no_divide     <= nd_r[QBITS];
  end

  // A word leaves only if a matching input word was taken.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && rst_n, LATENCY))
    else $error("result word without a matching input word");

  // The flipped y travels unchanged alongside the arithmetic.
  a_flip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_flipped_src_y ==
      sat16($signed(19'(DISPLAY_HEIGHT * 16)) - 19'($past(in_src_y, LATENCY))))
    else $error("flipped y does not match its input word");

endmodule
`default_nettype wire
